### hdl/zsfb_pkg.sv
// ---------------------------------------------------------------------------
// Z slab fog blend package
// Shared types, register indexes and pipeline constants.
// ---------------------------------------------------------------------------
package zsfb_pkg;

  localparam int DIV_LAT  = 32;
  localparam int SQRT_LAT = 32;
  localparam int ADDR_W   = 5;

  localparam logic signed [31:0] FLAT_LIMIT = 32'sd66;

  typedef enum logic [2:0] {
    REG_FOG_RED   = 3'd0,
    REG_FOG_GREEN = 3'd1,
    REG_FOG_BLUE  = 3'd2,
    REG_BOUND_ONE = 3'd3,
    REG_BOUND_TWO = 3'd4,
    REG_FAR_DIST  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_PATH,
    KIND_COLOR,
    KIND_FOG
  } kind_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic        hbig;
    logic        dz0;
    logic [31:0] h;
    logic [31:0] ux;
    logic [31:0] uy;
    rgb_t        color;
  } side_a_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
    rgb_t  color;
  } side_b_t;

endpackage

### hdl/zsfb_div.sv
// ---------------------------------------------------------------------------
// Pipelined divider
// Restoring division of a 64-bit numerator by a 32-bit divisor, one quotient
// bit per stage, with a flag for quotients that do not fit in 32 bits.
// ---------------------------------------------------------------------------
module zsfb_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        ovf
);

  localparam int N = zsfb_pkg::DIV_LAT;

  logic [31:0] rem_r [N];
  logic [31:0] low_r [N];
  logic [31:0] quo_r [N];
  logic [31:0] den_r [N];
  logic        ovf_r [N];

  logic [31:0] rem_in [N];
  logic [31:0] low_in [N];
  logic [31:0] quo_in [N];
  logic [31:0] den_in [N];
  logic        ovf_in [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [32:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = num[63:32];
      assign low_in[k] = num[31:0];
      assign quo_in[k] = '0;
      assign den_in[k] = den;
      assign ovf_in[k] = (num[63:32] >= den);
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign low_in[k] = low_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign den_in[k] = den_r[k-1];
      assign ovf_in[k] = ovf_r[k-1];
    end

    assign t  = {rem_in[k], low_in[k][31]};
    assign ge = (t >= {1'b0, den_in[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 32'(t - {1'b0, den_in[k]}) : t[31:0];
        low_r[k] <= {low_in[k][30:0], 1'b0};
        quo_r[k] <= {quo_in[k][30:0], ge};
        den_r[k] <= den_in[k];
        ovf_r[k] <= ovf_in[k];
      end
    end
  end

  assign quo = quo_r[N-1];
  assign ovf = ovf_r[N-1];

endmodule

### hdl/zsfb_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined square root
// Integer square root of a 64-bit radicand, one result bit per stage.
// ---------------------------------------------------------------------------
module zsfb_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int N = zsfb_pkg::SQRT_LAT;

  logic [63:0] n_r [N];
  logic [63:0] r_r [N];
  logic [63:0] n_in [N];
  logic [63:0] r_in [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign n_in[k] = rad;
      assign r_in[k] = '0;
    end else begin : g_next
      assign n_in[k] = n_r[k-1];
      assign r_in[k] = r_r[k-1];
    end

    assign t  = r_in[k] + BIT;
    assign ge = (n_in[k] >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= ge ? n_in[k] - t : n_in[k];
        r_r[k] <= ge ? (r_in[k] >> 1) + BIT : (r_in[k] >> 1);
      end
    end
  end

  assign root = r_r[N-1][31:0];

endmodule

### hdl/z_slab_fog_blend.sv
// Throughput: one beat per cycle; the pipeline depth is set by two ranks of
// 32-stage dividers and a 32-stage square root, and the whole pipeline holds
// while a result beat waits for out_ready. Reset clears all valid bits and
// loads the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Z slab fog blend
// Clips a segment or ray to a z slab, measures the path length inside it and
// blends the input colour linearly towards the fog colour.
// ---------------------------------------------------------------------------
module z_slab_fog_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [zsfb_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic signed [31:0]              in_first_x,
  input  logic signed [31:0]              in_first_y,
  input  logic signed [31:0]              in_first_z,
  input  logic signed [31:0]              in_second_x,
  input  logic signed [31:0]              in_second_y,
  input  logic signed [31:0]              in_second_z,
  input  logic [15:0]                     in_red,
  input  logic [15:0]                     in_green,
  input  logic [15:0]                     in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_red,
  output logic [15:0]                     out_green,
  output logic [15:0]                     out_blue
);

  localparam int DL = zsfb_pkg::DIV_LAT;
  localparam int SL = zsfb_pkg::SQRT_LAT;

  logic [15:0]        fog_red_r, fog_green_r, fog_blue_r;
  logic signed [31:0] bound_one_r, bound_two_r;
  logic [30:0]        far_r;
  logic               wr_en;
  logic signed [31:0] zlo, zhi;
  logic               adv;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fog_red_r   <= '0;
      fog_green_r <= '0;
      fog_blue_r  <= '0;
      bound_one_r <= 32'sd0;
      bound_two_r <= 32'sd65536;
      far_r       <= 31'd65536;
    end else if (wr_en) begin
      unique case (zsfb_pkg::reg_idx_t'(paddr[4:2]))
        zsfb_pkg::REG_FOG_RED:   fog_red_r   <= pwdata[15:0];
        zsfb_pkg::REG_FOG_GREEN: fog_green_r <= pwdata[15:0];
        zsfb_pkg::REG_FOG_BLUE:  fog_blue_r  <= pwdata[15:0];
        zsfb_pkg::REG_BOUND_ONE: bound_one_r <= pwdata;
        zsfb_pkg::REG_BOUND_TWO: bound_two_r <= pwdata;
        zsfb_pkg::REG_FAR_DIST:  far_r       <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (zsfb_pkg::reg_idx_t'(paddr[4:2]))
      zsfb_pkg::REG_FOG_RED:   prdata = {16'b0, fog_red_r};
      zsfb_pkg::REG_FOG_GREEN: prdata = {16'b0, fog_green_r};
      zsfb_pkg::REG_FOG_BLUE:  prdata = {16'b0, fog_blue_r};
      zsfb_pkg::REG_BOUND_ONE: prdata = bound_one_r;
      zsfb_pkg::REG_BOUND_TWO: prdata = bound_two_r;
      zsfb_pkg::REG_FAR_DIST:  prdata = {1'b0, far_r};
      default:                 prdata = '0;
    endcase
  end

  assign zlo = (bound_one_r < bound_two_r) ? bound_one_r : bound_two_r;
  assign zhi = (bound_one_r < bound_two_r) ? bound_two_r : bound_one_r;

  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: classify the beat and clip the z range.
  logic signed [31:0] zmin, zmax, seg_top, seg_bot, ray_top, ray_bot;
  logic               seg_out, flat, in_slab;
  logic [31:0]        mag_bz;
  logic signed [32:0] seg_dz;

  logic               s1_vld_r;
  zsfb_pkg::kind_t    s1_kind_r, s1_kind_nxt;
  logic signed [31:0] s1_top_r, s1_bot_r, s1_top_nxt, s1_bot_nxt;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_dx_nxt, s1_dy_nxt;
  logic [31:0]        s1_dz_r, s1_dz_nxt;
  zsfb_pkg::rgb_t     s1_color_r;

  always_comb begin
    zmin    = (in_first_z < in_second_z) ? in_first_z : in_second_z;
    zmax    = (in_first_z < in_second_z) ? in_second_z : in_first_z;
    seg_out = (in_first_z >= zhi && in_second_z >= zhi) ||
              (in_first_z <= zlo && in_second_z <= zlo);
    seg_top = (zmax < zhi) ? zmax : zhi;
    seg_bot = (zmin > zlo) ? zmin : zlo;
    seg_dz  = 33'(zmax) - 33'(zmin);
    flat    = (in_second_z > -zsfb_pkg::FLAT_LIMIT) && (in_second_z < zsfb_pkg::FLAT_LIMIT);
    in_slab = (in_first_z > zlo) && (in_first_z < zhi);
    mag_bz  = in_second_z[31] ? 32'(-{in_second_z[31], in_second_z})
                              : 32'(in_second_z);
    if (in_second_z > 32'sd0) begin
      ray_bot = (in_first_z > zlo) ? in_first_z : zlo;
      ray_top = zhi;
    end else begin
      ray_bot = zlo;
      ray_top = (in_first_z < zhi) ? in_first_z : zhi;
    end
    if (!in_opcode) begin
      s1_kind_nxt = seg_out ? zsfb_pkg::KIND_COLOR : zsfb_pkg::KIND_PATH;
      s1_top_nxt  = seg_top;
      s1_bot_nxt  = seg_bot;
      s1_dx_nxt   = 33'(in_second_x) - 33'(in_first_x);
      s1_dy_nxt   = 33'(in_second_y) - 33'(in_first_y);
      s1_dz_nxt   = seg_dz[31:0];
    end else begin
      if (flat) begin
        s1_kind_nxt = in_slab ? zsfb_pkg::KIND_FOG : zsfb_pkg::KIND_COLOR;
      end else begin
        s1_kind_nxt = zsfb_pkg::KIND_PATH;
      end
      s1_top_nxt = ray_top;
      s1_bot_nxt = ray_bot;
      s1_dx_nxt  = 33'(in_second_x);
      s1_dy_nxt  = 33'(in_second_y);
      s1_dz_nxt  = mag_bz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= s1_kind_nxt;
      s1_top_r   <= s1_top_nxt;
      s1_bot_r   <= s1_bot_nxt;
      s1_dx_r    <= s1_dx_nxt;
      s1_dy_r    <= s1_dy_nxt;
      s1_dz_r    <= s1_dz_nxt;
      s1_color_r <= '{red: in_red, green: in_green, blue: in_blue};
    end
  end

  // Stage 2: clipped height and horizontal extents.
  logic signed [32:0] hd;
  logic               s2_vld_r;
  zsfb_pkg::kind_t    s2_kind_r;
  logic [31:0]        s2_h_r, s2_ux_r, s2_uy_r, s2_dz_r;
  zsfb_pkg::rgb_t     s2_color_r;

  assign hd = 33'(s1_top_r) - 33'(s1_bot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r  <= s1_kind_r;
      s2_h_r     <= (hd > 33'sd0) ? hd[31:0] : 32'd0;
      s2_ux_r    <= s1_dx_r[32] ? 32'(-s1_dx_r) : s1_dx_r[31:0];
      s2_uy_r    <= s1_dy_r[32] ? 32'(-s1_dy_r) : s1_dy_r[31:0];
      s2_dz_r    <= s1_dz_r;
      s2_color_r <= s1_color_r;
    end
  end

  // Stage 3: scale the horizontal extents by the clipped height.
  zsfb_pkg::side_a_t s3_side_r;
  logic [63:0]       s3_px_r, s3_py_r;
  logic [31:0]       s3_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.vld <= 1'b0;
    end else if (adv) begin
      s3_side_r.vld <= s2_vld_r;
    end
    if (adv) begin
      s3_side_r.kind  <= s2_kind_r;
      s3_side_r.hbig  <= (s2_h_r > {1'b0, far_r});
      s3_side_r.dz0   <= (s2_dz_r == 32'd0);
      s3_side_r.h     <= s2_h_r;
      s3_side_r.ux    <= s2_ux_r;
      s3_side_r.uy    <= s2_uy_r;
      s3_side_r.color <= s2_color_r;
      s3_px_r         <= 64'(s2_ux_r) * 64'(s2_h_r);
      s3_py_r         <= 64'(s2_uy_r) * 64'(s2_h_r);
      s3_dz_r         <= s2_dz_r;
    end
  end

  logic [31:0] qx, qy;
  logic        ovx, ovy;

  zsfb_div u_div_x (
    .clk (clk), .en (adv), .num (s3_px_r), .den (s3_dz_r), .quo (qx), .ovf (ovx)
  );

  zsfb_div u_div_y (
    .clk (clk), .en (adv), .num (s3_py_r), .den (s3_dz_r), .quo (qy), .ovf (ovy)
  );

  zsfb_pkg::side_a_t dla_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        dla_r[i].vld <= 1'b0;
      end
    end else if (adv) begin
      dla_r[0] <= s3_side_r;
      for (int i = 1; i < DL; i++) begin
        dla_r[i] <= dla_r[i-1];
      end
    end
  end

  // Horizontal parts and range checks against the far distance.
  zsfb_pkg::side_a_t a_out;
  logic [31:0]       cx, cy;
  logic              fx, fy;
  zsfb_pkg::side_b_t sd_side_r, sq_side_r, sum_side_r;
  logic [30:0]       sd_cx_r, sd_cy_r, sd_h_r;
  logic [61:0]       sq_x_r, sq_y_r, sq_h_r;
  logic [63:0]       sum_r;

  assign a_out = dla_r[DL-1];
  assign cx    = a_out.dz0 ? a_out.ux : qx;
  assign cy    = a_out.dz0 ? a_out.uy : qy;
  assign fx    = (!a_out.dz0 && ovx) || (cx > {1'b0, far_r});
  assign fy    = (!a_out.dz0 && ovy) || (cy > {1'b0, far_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_side_r.vld  <= 1'b0;
      sq_side_r.vld  <= 1'b0;
      sum_side_r.vld <= 1'b0;
    end else if (adv) begin
      sd_side_r.vld  <= a_out.vld;
      sq_side_r.vld  <= sd_side_r.vld;
      sum_side_r.vld <= sq_side_r.vld;
    end
    if (adv) begin
      if (a_out.kind == zsfb_pkg::KIND_PATH && (a_out.hbig || fx || fy)) begin
        sd_side_r.kind <= zsfb_pkg::KIND_FOG;
      end else begin
        sd_side_r.kind <= a_out.kind;
      end
      sd_side_r.color <= a_out.color;
      sd_cx_r         <= cx[30:0];
      sd_cy_r         <= cy[30:0];
      sd_h_r          <= a_out.h[30:0];

      sq_side_r.kind  <= sd_side_r.kind;
      sq_side_r.color <= sd_side_r.color;
      sq_x_r          <= 62'(sd_cx_r) * 62'(sd_cx_r);
      sq_y_r          <= 62'(sd_cy_r) * 62'(sd_cy_r);
      sq_h_r          <= 62'(sd_h_r) * 62'(sd_h_r);

      sum_side_r.kind  <= sq_side_r.kind;
      sum_side_r.color <= sq_side_r.color;
      sum_r            <= 64'(sq_x_r) + 64'(sq_y_r) + 64'(sq_h_r);
    end
  end

  logic [31:0] path_len;

  zsfb_sqrt u_sqrt (
    .clk (clk), .en (adv), .rad (sum_r), .root (path_len)
  );

  zsfb_pkg::side_b_t dlb_r [SL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SL; i++) begin
        dlb_r[i].vld <= 1'b0;
      end
    end else if (adv) begin
      dlb_r[0] <= sum_side_r;
      for (int i = 1; i < SL; i++) begin
        dlb_r[i] <= dlb_r[i-1];
      end
    end
  end

  // Blend: colour * (far - dist) + fog * dist, rounded, over far.
  zsfb_pkg::side_b_t b_out;
  zsfb_pkg::side_b_t post_side_r, mul_side_r, add_side_r;
  logic [30:0]       post_dist_r, post_rem_r;
  logic [15:0]       col_ch [3];
  logic [15:0]       fog_ch [3];
  logic [46:0]       mc_r [3];
  logic [46:0]       mf_r [3];
  logic [47:0]       n_r [3];
  logic [31:0]       quo2 [3];
  logic              ovf2 [3];

  assign b_out = dlb_r[SL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_side_r.vld <= 1'b0;
      mul_side_r.vld  <= 1'b0;
      add_side_r.vld  <= 1'b0;
    end else if (adv) begin
      post_side_r.vld <= b_out.vld;
      mul_side_r.vld  <= post_side_r.vld;
      add_side_r.vld  <= mul_side_r.vld;
    end
    if (adv) begin
      if (b_out.kind == zsfb_pkg::KIND_PATH && path_len > {1'b0, far_r}) begin
        post_side_r.kind <= zsfb_pkg::KIND_FOG;
      end else if (b_out.kind == zsfb_pkg::KIND_PATH && path_len == 32'd0) begin
        post_side_r.kind <= zsfb_pkg::KIND_COLOR;
      end else begin
        post_side_r.kind <= b_out.kind;
      end
      post_side_r.color <= b_out.color;
      post_dist_r       <= path_len[30:0];
      post_rem_r        <= far_r - path_len[30:0];

      mul_side_r.kind   <= post_side_r.kind;
      mul_side_r.color  <= post_side_r.color;
      add_side_r.kind   <= mul_side_r.kind;
      add_side_r.color  <= mul_side_r.color;
    end
  end

  assign col_ch[0] = post_side_r.color.red;
  assign col_ch[1] = post_side_r.color.green;
  assign col_ch[2] = post_side_r.color.blue;
  assign fog_ch[0] = fog_red_r;
  assign fog_ch[1] = fog_green_r;
  assign fog_ch[2] = fog_blue_r;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    always_ff @(posedge clk) begin
      if (adv) begin
        mc_r[c] <= 47'(col_ch[c]) * 47'(post_rem_r);
        mf_r[c] <= 47'(fog_ch[c]) * 47'(post_dist_r);
        n_r[c]  <= 48'(mc_r[c]) + 48'(mf_r[c]) + 48'(far_r[30:1]);
      end
    end

    zsfb_div u_div_blend (
      .clk (clk),
      .en  (adv),
      .num ({16'b0, n_r[c]}),
      .den ({1'b0, far_r}),
      .quo (quo2[c]),
      .ovf (ovf2[c])
    );
  end

  zsfb_pkg::side_b_t dlc_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        dlc_r[i].vld <= 1'b0;
      end
    end else if (adv) begin
      dlc_r[0] <= add_side_r;
      for (int i = 1; i < DL; i++) begin
        dlc_r[i] <= dlc_r[i-1];
      end
    end
  end

  // Output register.
  zsfb_pkg::side_b_t c_out;
  logic [15:0]       out_red_r, out_green_r, out_blue_r;

  assign c_out = dlc_r[DL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (c_out.kind)
        zsfb_pkg::KIND_COLOR: begin
          out_red_r   <= c_out.color.red;
          out_green_r <= c_out.color.green;
          out_blue_r  <= c_out.color.blue;
        end
        zsfb_pkg::KIND_FOG: begin
          out_red_r   <= fog_red_r;
          out_green_r <= fog_green_r;
          out_blue_r  <= fog_blue_r;
        end
        default: begin
          out_red_r   <= quo2[0][15:0];
          out_green_r <= quo2[1][15:0];
          out_blue_r  <= quo2[2][15:0];
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  a_blend_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (c_out.vld && c_out.kind == zsfb_pkg::KIND_PATH) |->
      ((quo2[0][31:16] | quo2[1][31:16] | quo2[2][31:16]) == 16'd0 &&
       !ovf2[0] && !ovf2[1] && !ovf2[2]))
    else $error("blend quotient out of colour range");

  a_far_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && paddr[4:2] == zsfb_pkg::REG_FAR_DIST) |=> (far_r == $past(pwdata[30:0])))
    else $error("far distance register not written");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_vld_r && !c_out.vld)
    else $error("valid bits not cleared by reset");

endmodule
